### sv/heap_sort_descending_unit_assert.svh
// Assertion helpers for the heap sort unit; clk and rst come from the using scope.
`ifndef HEAP_SORT_DESCENDING_UNIT_ASSERT_SVH
`define HEAP_SORT_DESCENDING_UNIT_ASSERT_SVH

// Same-cycle implication.
`define HSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/hsd_pkg.sv
package hsd_pkg;

  localparam int HSD_CAPACITY = 64;
  localparam int HSD_DATA_W   = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD_RD,
    ST_BUILD_LD,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_EXT_RD,
    ST_EXT_EMIT
  } hsd_state_t;

endpackage

### sv/heap_sort_descending_unit.sv
// Heap sort unit, descending. Values arrive one per transaction, one per cycle while the
// unit is idle, and are written into a CAPACITY-entry memory until a transaction with
// last_item set; values past capacity are dropped and reported on every result of that
// set through overflow. The set is then ordered as a max-heap held in a single memory
// with two registered read ports and one write port, and the root is taken out
// repeatedly, giving results largest first with last_result on the final one. Input
// stall is high from the last item until the final result is loaded into the output
// register. Each sift-down level reads both children, then compares and writes back, and
// a value that lands on a leaf is written home in a step of its own. Taking out values
// waits while the result side stalls.
module heap_sort_descending_unit
  import hsd_pkg::*;
#(
  parameter int CAPACITY = HSD_CAPACITY
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic signed [HSD_DATA_W-1:0] value,
  input  logic                         last_item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic signed [HSD_DATA_W-1:0] sorted_value,
  output logic                         last_result,
  output logic                         overflow
);

  `include "heap_sort_descending_unit_assert.svh"

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic signed [HSD_DATA_W-1:0] heap_store [CAPACITY];

  hsd_state_t state, state_next;

  logic [CW-1:0] count;
  logic          dropped;
  logic [CW-1:0] heap_size;
  logic [CW-1:0] build_k;
  logic          building;
  logic [AW-1:0] node_idx;
  logic signed [HSD_DATA_W-1:0] node_val;
  logic signed [HSD_DATA_W-1:0] rd_a, rd_b;

  logic                         mem_we;
  logic [AW-1:0]                wr_addr;
  logic signed [HSD_DATA_W-1:0] wr_data;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr_a, rd_addr_b;

  logic          accept;
  logic          has_room;
  logic [CW-1:0] count_next;
  logic          dropped_next;
  logic [IW-1:0] left_idx, right_idx, size_ext;
  logic          has_left, right_ok, take_right, swap;
  logic [AW-1:0] child_idx;
  logic signed [HSD_DATA_W-1:0] child_val;
  logic          sift_done;
  logic          emit_go;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign has_room   = (count < CAP_C);
  assign count_next   = has_room ? count + CW'(1) : count;
  assign dropped_next = dropped || !has_room;

  assign left_idx  = {1'b0, node_idx, 1'b1};
  assign right_idx = {1'b0, node_idx, 1'b1} + IW'(1);
  assign size_ext  = IW'(heap_size);
  assign has_left  = (left_idx < size_ext);
  assign right_ok  = (right_idx < size_ext);

  assign take_right = right_ok && (rd_b > rd_a);
  assign child_val  = take_right ? rd_b : rd_a;
  assign child_idx  = take_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
  assign swap       = (child_val > node_val);

  assign sift_done = ((state == ST_SIFT_RD) && !has_left) ||
                     ((state == ST_SIFT_CMP) && !swap);
  assign emit_go   = (state == ST_EXT_EMIT) && (!result_valid || !result_stall);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && last_item) begin
          state_next = ((count_next >> 1) == '0) ? ST_EXT_RD : ST_BUILD_RD;
        end
      end
      ST_BUILD_RD: state_next = ST_BUILD_LD;
      ST_BUILD_LD: state_next = ST_SIFT_RD;
      ST_SIFT_RD, ST_SIFT_CMP: begin
        if (sift_done) begin
          state_next = (building && build_k != '0) ? ST_BUILD_RD : ST_EXT_RD;
        end else if (state == ST_SIFT_RD) begin
          state_next = ST_SIFT_CMP;
        end else begin
          state_next = ST_SIFT_RD;
        end
      end
      ST_EXT_RD: state_next = ST_EXT_EMIT;
      ST_EXT_EMIT: begin
        if (emit_go) begin
          state_next = (heap_size == CW'(1)) ? ST_IDLE : ST_SIFT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    mem_we    = 1'b0;
    wr_addr   = node_idx;
    wr_data   = node_val;
    rd_en     = 1'b0;
    rd_addr_a = '0;
    rd_addr_b = '0;
    case (state)
      ST_IDLE: begin
        mem_we  = accept && has_room;
        wr_addr = count[AW-1:0];
        wr_data = value;
      end
      ST_BUILD_RD: begin
        rd_en     = 1'b1;
        rd_addr_a = AW'(build_k - CW'(1));
      end
      ST_SIFT_RD: begin
        if (has_left) begin
          rd_en     = 1'b1;
          rd_addr_a = left_idx[AW-1:0];
          rd_addr_b = right_idx[AW-1:0];
        end else begin
          mem_we = 1'b1;
        end
      end
      ST_SIFT_CMP: begin
        mem_we  = 1'b1;
        wr_data = swap ? child_val : node_val;
      end
      ST_EXT_RD: begin
        rd_en     = 1'b1;
        rd_addr_b = AW'(heap_size - CW'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_store[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a <= heap_store[rd_addr_a];
      rd_b <= heap_store[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      dropped      <= 1'b0;
      building     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_go) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (accept) begin
        count   <= count_next;
        dropped <= dropped_next;
        if (last_item) begin
          building <= ((count_next >> 1) != '0);
        end
      end
      if (sift_done && building && build_k == '0) begin
        building <= 1'b0;
      end
      if (emit_go && heap_size == CW'(1)) begin
        count   <= '0;
        dropped <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (accept && last_item) begin
      heap_size <= count_next;
      build_k   <= count_next >> 1;
    end
    case (state)
      ST_BUILD_RD: begin
        node_idx <= AW'(build_k - CW'(1));
        build_k  <= build_k - CW'(1);
      end
      ST_BUILD_LD: node_val <= rd_a;
      ST_SIFT_CMP: begin
        if (swap) begin
          node_idx <= child_idx;
        end
      end
      ST_EXT_EMIT: begin
        if (emit_go) begin
          sorted_value <= rd_a;
          last_result  <= (heap_size == CW'(1));
          overflow     <= dropped;
          heap_size    <= heap_size - CW'(1);
          node_idx     <= '0;
          node_val     <= rd_b;
        end
      end
      default: begin
      end
    endcase
  end

  `HSD_ASSERT_NOW(a_count_bound, 1'b1, count <= CAP_C, "element count beyond capacity")
  `HSD_ASSERT_NOW(a_no_rw_clash, mem_we && rd_en,
                  wr_addr != rd_addr_a && wr_addr != rd_addr_b,
                  "read and write of the same entry in one cycle")
  `HSD_ASSERT_NEXT(a_final_clears, emit_go && heap_size == CW'(1),
                   count == '0 && !dropped && last_result,
                   "set not closed after final result")

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import hsd_pkg::*;

  localparam int ITEM_TARGET    = 460;
  localparam int DIRECTED_ROWS  = 21;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 200;
  localparam int IDLE_PCT       = 19;
  localparam logic signed [HSD_DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [HSD_DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [HSD_DATA_W-1:0] v;
    logic                         lst;
    logic                         ovf;
  } sorted_result_t;

  typedef struct packed {
    logic signed [HSD_DATA_W-1:0] v;
    logic                         lst;
    logic                         typed;
  } stim_row_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         item_valid;
  logic                         item_stall;
  logic signed [HSD_DATA_W-1:0] value;
  logic                         last_item;
  logic                         result_valid;
  logic                         result_stall;
  logic signed [HSD_DATA_W-1:0] sorted_value;
  logic                         last_result;
  logic                         overflow;

  // model of the current data set and the results it owes
  logic signed [HSD_DATA_W-1:0] set_values[$];
  logic                         set_dropped;
  sorted_result_t               expected_results[$];

  int items_accepted;
  int results_seen;
  int errors;

  // single-item sets carry their own expectation; the rest go through the sorter model
  stim_row_t stim_table [0:DIRECTED_ROWS-1] = '{
    '{VAL_MAX,        1'b1, 1'b1},
    '{VAL_MIN,        1'b1, 1'b1},
    '{32'sh0000_0000, 1'b1, 1'b1},
    '{32'shFFFF_FFFF, 1'b1, 1'b1},
    '{32'sh0000_0005, 1'b0, 1'b0},
    '{32'shFFFF_FFFB, 1'b0, 1'b0},
    '{32'sh0000_0005, 1'b0, 1'b0},
    '{VAL_MIN,        1'b0, 1'b0},
    '{VAL_MAX,        1'b1, 1'b0},
    '{32'sh0000_0003, 1'b0, 1'b0},
    '{32'sh0000_0002, 1'b0, 1'b0},
    '{32'sh0000_0001, 1'b0, 1'b0},
    '{32'sh0000_0000, 1'b1, 1'b0},
    '{32'shFFFF_FFFD, 1'b0, 1'b0},
    '{32'shFFFF_FFFE, 1'b0, 1'b0},
    '{32'shFFFF_FFFF, 1'b0, 1'b0},
    '{32'sh0000_0000, 1'b1, 1'b0},
    '{32'sh5555_5555, 1'b0, 1'b0},
    '{32'shAAAA_AAAA, 1'b0, 1'b0},
    '{32'sh0F0F_0F0F, 1'b0, 1'b0},
    '{32'shF0F0_F0F0, 1'b1, 1'b0}
  };

  heap_sort_descending_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .value        (value),
    .last_item    (last_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sorted_value (sorted_value),
    .last_result  (last_result),
    .overflow     (overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // store a value, and on the last one also order the set largest first and queue its results
  task automatic absorb_value(input logic signed [HSD_DATA_W-1:0] v, input logic l);
    logic signed [HSD_DATA_W-1:0] ordered[$];
    logic signed [HSD_DATA_W-1:0] key;
    int j;
    if (set_values.size() < HSD_CAPACITY) begin
      set_values.push_back(v);
    end else begin
      set_dropped = 1'b1;
    end
    if (!l) return;
    ordered = set_values;
    for (int i = 1; i < ordered.size(); i++) begin
      key = ordered[i];
      j = i - 1;
      while (j >= 0 && ordered[j] < key) begin
        ordered[j+1] = ordered[j];
        j--;
      end
      ordered[j+1] = key;
    end
    for (int k = 0; k < ordered.size(); k++) begin
      expected_results.push_back(sorted_result_t'{ordered[k], (k == ordered.size() - 1),
                                                  set_dropped});
    end
    set_values.delete();
    set_dropped = 1'b0;
  endtask

  task automatic offer_item(input logic signed [HSD_DATA_W-1:0] v, input logic l,
                            input logic typed);
    // no gaps in the middle stretch of the run
    while (!(items_accepted >= 180 && items_accepted < 300) &&
           ($urandom_range(99) < IDLE_PCT)) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    value      <= v;
    last_item  <= l;
    do @(posedge clk); while (item_stall);
    items_accepted++;
    if (typed) begin
      expected_results.push_back(sorted_result_t'{v, 1'b1, 1'b0});
    end else begin
      absorb_value(v, l);
    end
  endtask

  function automatic logic signed [HSD_DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return VAL_MAX;
    if (r < 6) return VAL_MIN;
    if (r < 8) return '0;
    if (r < 10) return '1;
    if (r < 22) return $signed($urandom_range(15)) - 8;
    // repeat an earlier value of this set to get ties
    if (r < 30 && set_values.size() != 0) return set_values[$urandom_range(set_values.size() - 1)];
    return $urandom;
  endfunction

  initial begin
    int set_index;
    int set_size;
    int unsigned r;
    rst          <= 1'b1;
    item_valid   <= 1'b0;
    value        <= '0;
    last_item    <= 1'b0;
    set_dropped  = 1'b0;
    items_accepted = 0;
    errors       = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      offer_item(stim_table[i].v, stim_table[i].lst, stim_table[i].typed);
    end

    set_index = 0;
    while (items_accepted < ITEM_TARGET) begin
      r = $urandom_range(99);
      if (set_index == 0) set_size = HSD_CAPACITY;
      else if (set_index == 1) set_size = HSD_CAPACITY + 1;
      else if (r < 3) set_size = $urandom_range(HSD_CAPACITY + 6, HSD_CAPACITY - 2);
      else if (r < 8) set_size = $urandom_range(40, 13);
      else set_size = $urandom_range(12, 1);
      for (int k = 0; k < set_size; k++) begin
        offer_item(pick_value(), (k == set_size - 1), 1'b0);
      end
      set_index++;
    end
    item_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("heap_sort_descending_unit verification clean");
    end else begin
      $display("heap_sort_descending_unit verification failed");
    end
    $finish;
  end

  // receiver: random stalls, one long hold while the sender keeps offering, a quiet stretch
  initial begin
    bit held;
    held = 1'b0;
    result_stall <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && results_seen >= 20) begin
        held = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (results_seen >= 150 && results_seen < 260) begin
        result_stall <= 1'b0;
      end else begin
        result_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : result_check
    sorted_result_t want;
    if (rst) begin
      results_seen <= 0;
    end else if (result_valid && !result_stall) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $error("unexpected transaction: sorted_value %0d", sorted_value);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (sorted_value !== want.v) begin
          $error("sorted_value expected %0d actual %0d", want.v, sorted_value);
          errors++;
        end
        if (last_result !== want.lst) begin
          $error("last_result expected %0b actual %0b", want.lst, last_result);
          errors++;
        end
        if (overflow !== want.ovf) begin
          $error("overflow expected %0b actual %0b", want.ovf, overflow);
          errors++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("heap_sort_descending_unit verification failed");
    $finish;
  end

endmodule
